[hdl/hbs_pkg.sv]
`timescale 1ns / 1ps

package hbs_pkg;

   localparam int PIXEL_COUNT_DEFAULT = 16384;
   localparam int ENTRIES_DEFAULT     = 8;

   localparam int PIX_IN_W = 14;
   localparam int PIX_W    = 20;
   localparam int CHAN_W   = 8;
   localparam int Q_W      = 4;
   localparam int BIN_W    = 12;
   localparam int CNT_W    = 16;
   localparam int FILL_W   = 4;
   localparam int SUM_W    = 20;
   localparam int LIM_W    = SUM_W + 2;
   localparam int TF_W     = 16;
   localparam int THR_W    = 8;
   localparam int CSR_W    = 16;

   localparam logic [TF_W-1:0]  TRAIN_FRAMES_RESET    = 16'd100;
   localparam logic [THR_W-1:0] MATCH_THRESHOLD_RESET = 8'd50;
   localparam logic [CNT_W-1:0] COUNT_MAX             = 16'hFFFF;
   localparam logic [Q_W-1:0]   BIN_HALF              = 4'd8;

   typedef enum logic {
      OP_TRAIN = 1'b0,
      OP_TEST  = 1'b1
   } op_type;

   typedef enum logic {
      CSR_TRAIN_FRAMES    = 1'b0,
      CSR_MATCH_THRESHOLD = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EXEC
   } back_state_type;

   typedef struct packed {
      op_type              op;
      logic                in_range;
      logic [PIX_W-1:0]    pixel;
      logic [BIN_W-1:0]    bin;
      logic [CHAN_W-1:0]   blue;
      logic [CHAN_W-1:0]   green;
      logic [CHAN_W-1:0]   red;
   } item_type;

   function automatic logic chan_near(input logic [CHAN_W-1:0] value,
                                      input logic [Q_W-1:0] q,
                                      input logic [THR_W-1:0] thr);
      logic [CHAN_W-1:0] centre;
      logic [CHAN_W-1:0] delta;
      centre = {q, BIN_HALF};
      delta = (value > centre) ? value - centre : centre - value;
      return delta <= thr;
   endfunction

endpackage

[hdl/histogram_background_subtractor.sv]
`timescale 1ns / 1ps
// A request word is held in the front end's buffer, then taken, read and executed by
// the back end before its result word is registered, and longer while the result side stalls.
// The back end handles one word at a time: it takes, reads and updates with write
// back one pixel's wide histogram word before it takes the next request word.
// Reset: synchronous; afterwards every pixel memory word is swept to zero to clear
// fill counts, and no request word is taken during that sweep.

module histogram_background_subtractor import hbs_pkg::*; #(
   parameter int PIXEL_COUNT = PIXEL_COUNT_DEFAULT,
   parameter int ENTRIES     = ENTRIES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_op,
   input  logic [PIX_IN_W-1:0] req_pixel_index,
   input  logic [CHAN_W-1:0]   req_blue,
   input  logic [CHAN_W-1:0]   req_green,
   input  logic [CHAN_W-1:0]   req_red,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_foreground,
   output logic                rsp_list_full,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic [CSR_W-1:0]    csr_data
);

   logic [TF_W-1:0]  train_frames_ff;
   logic [THR_W-1:0] match_threshold_ff;
   logic             item_valid;
   item_type         item;
   logic             item_pop;
   logic             clearing;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         train_frames_ff    <= TRAIN_FRAMES_RESET;
         match_threshold_ff <= MATCH_THRESHOLD_RESET;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_TRAIN_FRAMES:    train_frames_ff    <= csr_data;
            CSR_MATCH_THRESHOLD: match_threshold_ff <= csr_data[THR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   hbs_front #(
      .PIXEL_COUNT(PIXEL_COUNT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_pixel_index (req_pixel_index),
      .req_blue        (req_blue),
      .req_green       (req_green),
      .req_red         (req_red),
      .clearing        (clearing),
      .item_valid      (item_valid),
      .item            (item),
      .item_pop        (item_pop)
   );

   hbs_back #(
      .PIXEL_COUNT(PIXEL_COUNT),
      .ENTRIES    (ENTRIES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (item_valid),
      .item            (item),
      .item_pop        (item_pop),
      .clearing        (clearing),
      .train_frames    (train_frames_ff),
      .match_threshold (match_threshold_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_foreground  (rsp_foreground),
      .rsp_list_full   (rsp_list_full)
   );

endmodule

[hdl/hbs_front.sv]
`timescale 1ns / 1ps

module hbs_front import hbs_pkg::*; #(
   parameter int PIXEL_COUNT = PIXEL_COUNT_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_op,
   input  logic [PIX_IN_W-1:0] req_pixel_index,
   input  logic [CHAN_W-1:0]   req_blue,
   input  logic [CHAN_W-1:0]   req_green,
   input  logic [CHAN_W-1:0]   req_red,
   input  logic                clearing,
   output logic                item_valid,
   output item_type            item,
   input  logic                item_pop
);

   item_type   slot_ff [2];
   item_type   new_item;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   assign req_ready  = (count_ff != 2'd2) && !clearing;
   assign push       = req_valid && req_ready;
   assign item_valid = (count_ff != 2'd0);
   assign item       = slot_ff[rd_ptr_ff];

   always_comb begin
      new_item.op       = op_type'(req_op);
      new_item.in_range = (32'(req_pixel_index) < 32'(PIXEL_COUNT));
      new_item.pixel    = PIX_W'(req_pixel_index);
      new_item.bin      = {req_blue[CHAN_W-1 -: Q_W], req_green[CHAN_W-1 -: Q_W],
                           req_red[CHAN_W-1 -: Q_W]};
      new_item.blue     = req_blue;
      new_item.green    = req_green;
      new_item.red      = req_red;
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = item_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(item_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

[hdl/hbs_back.sv]
`timescale 1ns / 1ps

module hbs_back import hbs_pkg::*; #(
   parameter int PIXEL_COUNT = PIXEL_COUNT_DEFAULT,
   parameter int ENTRIES     = ENTRIES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             item_valid,
   input  item_type         item,
   output logic             item_pop,
   output logic             clearing,
   input  logic [TF_W-1:0]  train_frames,
   input  logic [THR_W-1:0] match_threshold,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_foreground,
   output logic             rsp_list_full
);

   localparam int AW     = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
   localparam int EW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int SLOT_W = BIN_W + CNT_W;
   localparam int WORD_W = FILL_W + ENTRIES * SLOT_W;

   logic [WORD_W-1:0] mem [PIXEL_COUNT];

   back_state_type    state_ff, state_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   item_type          cur_ff, cur_in;
   logic [WORD_W-1:0] rd_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_fg_ff, rsp_fg_in;
   logic              rsp_full_ff, rsp_full_in;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [WORD_W-1:0] mem_wdata;

   logic [BIN_W-1:0]  ent_bins [ENTRIES];
   logic [CNT_W-1:0]  cnts  [ENTRIES];
   logic [BIN_W-1:0]  nbins [ENTRIES];
   logic [CNT_W-1:0]  ncnts [ENTRIES];
   logic [FILL_W-1:0] fill, nfill;
   logic [SUM_W-1:0]  sum;
   logic [LIM_W-1:0]  limit;
   logic              background;
   logic              hit;
   logic [EW-1:0]     hit_idx;
   logic [EW-1:0]     pos;
   logic [CNT_W-1:0]  old_cnt, new_cnt;
   logic              full_drop;
   logic [WORD_W-1:0] new_word;

   assign clearing       = (state_ff == ST_CLEAR);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_foreground = rsp_fg_ff;
   assign rsp_list_full  = rsp_full_ff;

   always_comb begin
      fill = rd_data_ff[FILL_W-1:0];
      if (fill > FILL_W'(ENTRIES)) begin
         fill = FILL_W'(ENTRIES);
      end
      for (int k = 0; k < ENTRIES; k++) begin
         ent_bins[k] = rd_data_ff[FILL_W + k*SLOT_W +: BIN_W];
         cnts[k] = rd_data_ff[FILL_W + k*SLOT_W + BIN_W +: CNT_W];
      end

      limit = LIM_W'({train_frames, 1'b0}) + LIM_W'(train_frames);
      sum = '0;
      background = 1'b0;
      for (int k = 0; k < ENTRIES; k++) begin
         if ((FILL_W'(k) < fill) && (LIM_W'({sum, 2'b00}) < limit) &&
             chan_near(cur_ff.blue, ent_bins[k][BIN_W-1 -: Q_W], match_threshold) &&
             chan_near(cur_ff.green, ent_bins[k][2*Q_W-1 -: Q_W], match_threshold) &&
             chan_near(cur_ff.red, ent_bins[k][Q_W-1:0], match_threshold)) begin
            background = 1'b1;
         end
         sum = sum + SUM_W'(cnts[k]);
      end

      hit = 1'b0;
      hit_idx = '0;
      for (int k = 0; k < ENTRIES; k++) begin
         if (!hit && (FILL_W'(k) < fill) && (ent_bins[k] == cur_ff.bin)) begin
            hit = 1'b1;
            hit_idx = EW'(k);
         end
      end
      old_cnt = cnts[hit_idx];
      new_cnt = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + CNT_W'(1);
      pos = '0;
      for (int k = 0; k < ENTRIES; k++) begin
         if ((EW'(k) < hit_idx) && (cnts[k] >= new_cnt)) begin
            pos = pos + EW'(1);
         end
      end

      full_drop = 1'b0;
      nfill = fill;
      for (int k = 0; k < ENTRIES; k++) begin
         nbins[k] = ent_bins[k];
         ncnts[k] = cnts[k];
      end
      if (hit) begin
         for (int k = 0; k < ENTRIES; k++) begin
            if (EW'(k) == pos) begin
               nbins[k] = cur_ff.bin;
               ncnts[k] = new_cnt;
            end else if ((EW'(k) > pos) && (EW'(k) <= hit_idx)) begin
               nbins[k] = ent_bins[(k > 0) ? k - 1 : 0];
               ncnts[k] = cnts[(k > 0) ? k - 1 : 0];
            end
         end
      end else if (fill >= FILL_W'(ENTRIES)) begin
         full_drop = 1'b1;
      end else begin
         for (int k = 0; k < ENTRIES; k++) begin
            if (FILL_W'(k) == fill) begin
               nbins[k] = cur_ff.bin;
               ncnts[k] = CNT_W'(1);
            end
         end
         nfill = fill + FILL_W'(1);
      end

      new_word[FILL_W-1:0] = nfill;
      for (int k = 0; k < ENTRIES; k++) begin
         new_word[FILL_W + k*SLOT_W +: SLOT_W] = {ncnts[k], nbins[k]};
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      cur_in       = cur_ff;
      item_pop     = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = cur_ff.pixel[AW-1:0];
      mem_wdata    = new_word;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_fg_in    = rsp_fg_ff;
      rsp_full_in  = rsp_full_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
            mem_wdata = '0;
            if (clr_addr_ff == AW'(PIXEL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               cur_in   = item;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_fg_in    = cur_ff.in_range && (cur_ff.op == OP_TEST) && !background;
               rsp_full_in  = cur_ff.in_range && (cur_ff.op == OP_TRAIN) && full_drop;
               mem_we       = cur_ff.in_range && (cur_ff.op == OP_TRAIN) && !full_drop;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_fg_ff   <= rsp_fg_in;
      rsp_full_ff <= rsp_full_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (state_ff == ST_READ) begin
         rd_data_ff <= mem[cur_ff.pixel[AW-1:0]];
      end
   end

endmodule

[hdl/hbs_checker.sv]
`timescale 1ns / 1ps

module hbs_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_foreground,
   input logic rsp_list_full
);

   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   a_no_req_during_sweep: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken while the memory is being cleared");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_foreground && rsp_list_full))
      else $error("a result word flags both foreground and a full list");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_foreground) &&
         $stable(rsp_list_full))
      else $error("stalled result word changed");

endmodule

bind histogram_background_subtractor hbs_checker u_hbs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_foreground (rsp_foreground),
   .rsp_list_full  (rsp_list_full)
);

[verif/tb_histogram_background_subtractor.sv]
`timescale 1ns / 1ps

module tb_histogram_background_subtractor;
   import hbs_pkg::*;

   localparam int NPIX = 16384;
   localparam int NENT = 8;
   localparam int STALL_LIMIT = 100000;

   typedef struct {
      logic foreground;
      logic list_full;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_op = 1'b0;
   logic [PIX_IN_W-1:0] req_pixel_index = '0;
   logic [CHAN_W-1:0] req_blue = '0;
   logic [CHAN_W-1:0] req_green = '0;
   logic [CHAN_W-1:0] req_red = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_foreground;
   logic rsp_list_full;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = 1'b0;
   logic [CSR_W-1:0] csr_data = '0;

   logic [BIN_W-1:0] hist_bin [NPIX][NENT];
   logic [CNT_W-1:0] hist_cnt [NPIX][NENT];
   logic [FILL_W-1:0] hist_fill [NPIX];
   logic [TF_W-1:0] model_frames;
   logic [THR_W-1:0] model_thr;

   verdict_type pending_verdicts[$];
   int errors = 0;
   int quiet_cycles = 0;
   bit idle_on = 1'b1;

   histogram_background_subtractor dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit chan_close(logic [CHAN_W-1:0] value, logic [Q_W-1:0] q);
      int centre;
      int delta;
      centre = q * 16 + 8;
      delta = (value > centre) ? value - centre : centre - value;
      return delta <= model_thr;
   endfunction

   function automatic logic train_pixel(int pix, logic [BIN_W-1:0] bin);
      int fill;
      int i;
      logic [BIN_W-1:0] tb;
      logic [CNT_W-1:0] tc;
      fill = hist_fill[pix];
      if (fill > NENT) fill = NENT;
      for (i = 0; i < fill; i++)
         if (hist_bin[pix][i] == bin) break;
      if (i == fill) begin
         if (fill >= NENT) return 1'b1;
         hist_bin[pix][fill] = bin;
         hist_cnt[pix][fill] = CNT_W'(1);
         hist_fill[pix] = FILL_W'(fill + 1);
         return 1'b0;
      end
      if (hist_cnt[pix][i] != COUNT_MAX) hist_cnt[pix][i] = hist_cnt[pix][i] + CNT_W'(1);
      while (i > 0 && hist_cnt[pix][i-1] < hist_cnt[pix][i]) begin
         tb = hist_bin[pix][i-1];
         tc = hist_cnt[pix][i-1];
         hist_bin[pix][i-1] = hist_bin[pix][i];
         hist_cnt[pix][i-1] = hist_cnt[pix][i];
         hist_bin[pix][i] = tb;
         hist_cnt[pix][i] = tc;
         i--;
      end
      return 1'b0;
   endfunction

   function automatic logic test_pixel(int pix, logic [7:0] b, logic [7:0] g, logic [7:0] r);
      int fill;
      longint sum;
      longint lim;
      logic [BIN_W-1:0] bin;
      fill = hist_fill[pix];
      if (fill > NENT) fill = NENT;
      sum = 0;
      lim = 3 * longint'(model_frames);
      for (int i = 0; i < fill && 4 * sum < lim; i++) begin
         bin = hist_bin[pix][i];
         if (chan_close(b, bin[11:8]) && chan_close(g, bin[7:4]) && chan_close(r, bin[3:0]))
            return 1'b0;
         sum += hist_cnt[pix][i];
      end
      return 1'b1;
   endfunction

   function automatic verdict_type classify_pixel(logic op, int pix, logic [7:0] b,
                                                   logic [7:0] g, logic [7:0] r);
      verdict_type v;
      v.foreground = 1'b0;
      v.list_full = 1'b0;
      if (pix >= NPIX) return v;
      if (op == OP_TRAIN) v.list_full = train_pixel(pix, {b[7:4], g[7:4], r[7:4]});
      else v.foreground = test_pixel(pix, b, g, r);
      return v;
   endfunction

   task automatic report_mismatch(string what, logic want, logic got);
      $display("MISMATCH %s: expected %0b, got %0b at %0t", what, want, got, $realtime);
      errors++;
   endtask

   always @(posedge clock) begin
      verdict_type v;
      if (!reset) begin
         if (req_valid && req_ready || rsp_valid && rsp_ready || csr_valid && csr_ready)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
         if (req_valid && req_ready)
            pending_verdicts = {pending_verdicts,
                                classify_pixel(req_op, req_pixel_index, req_blue,
                                               req_green, req_red)};
         if (rsp_valid && rsp_ready) begin
            if (pending_verdicts.size() == 0) begin
               report_mismatch("result word with nothing expected", 1'b0, 1'b1);
            end else begin
               v = pending_verdicts.pop_front();
               if (v.foreground !== rsp_foreground)
                  report_mismatch("foreground", v.foreground, rsp_foreground);
               if (v.list_full !== rsp_list_full)
                  report_mismatch("list_full", v.list_full, rsp_list_full);
            end
         end
      end
   end

   initial begin
      int n;
      forever begin
         n = idle_on ? $urandom_range(0, 19) : 0;
         if (n > 0) begin
            @(negedge clock);
            rsp_ready = 1'b0;
            repeat (n - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_pixel(logic op, int pix, logic [7:0] b, logic [7:0] g, logic [7:0] r);
      int gap;
      gap = idle_on ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_op = op;
      req_pixel_index = PIX_IN_W'(pix);
      req_blue = b;
      req_green = g;
      req_red = r;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_verdicts.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [CSR_W-1:0] value);
      drain_results();
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_TRAIN_FRAMES) model_frames = value;
      else model_thr = value[THR_W-1:0];
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic test_directed();
      send_pixel(OP_TEST, 0, 8'd0, 8'd0, 8'd0);
      send_pixel(OP_TRAIN, 0, 8'd0, 8'd0, 8'd0);
      send_pixel(OP_TEST, 0, 8'd5, 8'd50, 8'd58);
      send_pixel(OP_TEST, 0, 8'd255, 8'd255, 8'd255);
      send_pixel(OP_TRAIN, NPIX - 1, 8'd255, 8'd255, 8'd255);
      send_pixel(OP_TEST, NPIX - 1, 8'd255, 8'd255, 8'd255);
      send_pixel(OP_TEST, NPIX - 1, 8'd0, 8'd0, 8'd0);
      for (int k = 0; k < NENT; k++)
         send_pixel(OP_TRAIN, 1, 8'(k * 32), 8'(255 - k * 32), 8'd128);
      send_pixel(OP_TRAIN, 1, 8'd17, 8'd17, 8'd17);
      send_pixel(OP_TRAIN, 1, 8'd224, 8'd31, 8'd128);
      send_pixel(OP_TRAIN, 1, 8'd224, 8'd31, 8'd128);
      send_pixel(OP_TEST, 1, 8'd230, 8'd20, 8'd130);
      send_pixel(OP_TEST, 1, 8'd17, 8'd17, 8'd17);
      send_pixel(OP_TEST, 1, 8'd0, 8'd255, 8'd128);
   endtask

   task automatic test_random(int count);
      logic [7:0] pal [10][3];
      int pix;
      int np;
      int k;
      int sent;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) == 0) begin
            send_pixel(1'($urandom_range(0, 1)), $urandom_range(0, NPIX - 1),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
            sent++;
         end else begin
            pix = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 63) : $urandom_range(0, NPIX - 1);
            np = $urandom_range(1, 10);
            for (int p = 0; p < np; p++)
               for (int c = 0; c < 3; c++)
                  pal[p][c] = 8'($urandom_range(0, 255));
            repeat ($urandom_range(1, 14)) begin
               k = $urandom_range(0, np - 1);
               send_pixel(OP_TRAIN, pix, pal[k][0] ^ 8'($urandom_range(0, 15)),
                          pal[k][1] ^ 8'($urandom_range(0, 15)),
                          pal[k][2] ^ 8'($urandom_range(0, 15)));
               sent++;
            end
            repeat ($urandom_range(1, 5)) begin
               k = $urandom_range(0, np - 1);
               if ($urandom_range(0, 3) == 0)
                  send_pixel(OP_TEST, pix, 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
               else
                  send_pixel(OP_TEST, pix, pal[k][0] ^ 8'($urandom_range(0, 63)),
                             pal[k][1] ^ 8'($urandom_range(0, 63)),
                             pal[k][2] ^ 8'($urandom_range(0, 63)));
               sent++;
            end
         end
      end
   endtask

   task automatic test_repeated_bin();
      idle_on = 1'b0;
      repeat (30) send_pixel(OP_TRAIN, 9000, 8'd40, 8'd90, 8'd200);
      send_pixel(OP_TRAIN, 9000, 8'd200, 8'd90, 8'd40);
      send_pixel(OP_TEST, 9000, 8'd40, 8'd90, 8'd200);
      send_pixel(OP_TEST, 9000, 8'd200, 8'd90, 8'd40);
      idle_on = 1'b1;
   endtask

   task automatic test_settings();
      logic [CSR_W-1:0] frames [6] = '{16'd1, 16'd65535, 16'd0, 16'd3, 16'd20, 16'd100};
      logic [CSR_W-1:0] thrs [6] = '{16'h0000, 16'hFFFF, 16'h001E, 16'hFF08, 16'h00FF, 16'h0032};
      for (int s = 0; s < 6; s++) begin
         write_register(CSR_TRAIN_FRAMES, frames[s]);
         write_register(CSR_MATCH_THRESHOLD, thrs[s]);
         idle_on = (s != 2);
         test_random(150);
         idle_on = 1'b1;
      end
   endtask

   initial begin
      for (int p = 0; p < NPIX; p++) hist_fill[p] = '0;
      model_frames = TRAIN_FRAMES_RESET;
      model_thr = MATCH_THRESHOLD_RESET;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(200);
      test_repeated_bin();
      test_settings();
      drain_results();
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

[histogram_background_subtractor.f]
hdl/hbs_pkg.sv
hdl/hbs_front.sv
hdl/hbs_back.sv
hdl/histogram_background_subtractor.sv
hdl/hbs_checker.sv
verif/tb_histogram_background_subtractor.sv
